// ===== hdl/mfe_pkg.sv =====
// Shared types and constants for the most_frequent_element block.
// No dependencies; used by mfe_cell and most_frequent_element.
`timescale 1ns / 1ps
`default_nettype none

package mfe_pkg;

   // default capacity of one set, in items
   localparam int DEFAULT_MAX_ITEMS = 256;

   // width of the reported count and its saturation point
   localparam int COUNT_W = 9;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 9'd511;

   // one input item
   typedef struct packed {
      logic signed [31:0] value;
      logic               last;
   } req_item_type;

   // one result item
   typedef struct packed {
      logic signed [31:0]       mode_value;
      logic [COUNT_W-1:0]       mode_count;
      logic                     overflow;
   } rsp_item_type;

   // control part of a token moving down the cell chain
   typedef struct packed {
      logic valid;      // slot holds a token
      logic has_value;  // value still looking for its cell
      logic last;       // token closes the set and collects the mode
      logic overflow;   // items of this set were dropped
   } token_ctrl_type;

endpackage : mfe_pkg

`default_nettype wire

// ===== hdl/mfe_cell.sv =====
// One cell of the mode chain: holds one distinct value and its count.
// Depends on mfe_pkg (token_ctrl_type).
`timescale 1ns / 1ps
`default_nettype none

module mfe_cell #(
   parameter int CNT_W = 9
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          advance,
   input  wire mfe_pkg::token_ctrl_type       up_ctrl,
   input  wire logic signed [31:0]            up_value,
   input  wire logic signed [31:0]            up_best_val,
   input  wire logic [CNT_W-1:0]              up_best_cnt,
   output mfe_pkg::token_ctrl_type            dn_ctrl,
   output logic signed [31:0]                 dn_value,
   output logic signed [31:0]                 dn_best_val,
   output logic [CNT_W-1:0]                   dn_best_cnt
);
   import mfe_pkg::*;

   logic                   occ_ff, occ_in;
   logic signed [31:0]     val_ff, val_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   token_ctrl_type         ctrl_ff, ctrl_in;
   logic signed [31:0]     value_ff;
   logic signed [31:0]     best_val_ff, best_val_in;
   logic [CNT_W-1:0]       best_cnt_ff, best_cnt_in;

   logic                   match;
   logic                   capture;
   logic                   cur_occ;
   logic signed [31:0]     cur_val;
   logic [CNT_W-1:0]       cur_cnt;
   logic                   better;

   // absorb the passing value: bump on a match, claim the cell when empty
   always_comb begin
      match   = up_ctrl.valid && up_ctrl.has_value && occ_ff && (val_ff == up_value);
      capture = up_ctrl.valid && up_ctrl.has_value && !occ_ff;
      cur_occ = occ_ff || capture;
      cur_val = capture ? up_value : val_ff;
      if (capture) begin
         cur_cnt = CNT_W'(1);
      end else if (match) begin
         cur_cnt = cnt_ff + CNT_W'(1);
      end else begin
         cur_cnt = cnt_ff;
      end
   end

   // the closing token keeps the higher count, the smaller value on a tie
   always_comb begin
      better = cur_occ && ((cur_cnt > up_best_cnt) ||
               ((cur_cnt == up_best_cnt) && (cur_val < up_best_val)));
   end

   // next cell contents and outgoing token
   always_comb begin
      ctrl_in           = up_ctrl;
      ctrl_in.has_value = up_ctrl.has_value && !(match || capture);
      best_val_in       = up_best_val;
      best_cnt_in       = up_best_cnt;
      val_in            = cur_val;
      cnt_in            = cur_cnt;
      occ_in            = cur_occ;
      if (up_ctrl.valid && up_ctrl.last) begin
         if (better) begin
            best_val_in = cur_val;
            best_cnt_in = cur_cnt;
         end
         occ_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff  <= 1'b0;
         ctrl_ff <= '0;
      end else if (advance) begin
         occ_ff  <= occ_in;
         ctrl_ff <= ctrl_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (advance) begin
         val_ff      <= val_in;
         cnt_ff      <= cnt_in;
         value_ff    <= up_value;
         best_val_ff <= best_val_in;
         best_cnt_ff <= best_cnt_in;
      end
   end

   assign dn_ctrl     = ctrl_ff;
   assign dn_value    = value_ff;
   assign dn_best_val = best_val_ff;
   assign dn_best_cnt = best_cnt_ff;

endmodule : mfe_cell

`default_nettype wire

// ===== hdl/most_frequent_element.sv =====
// Top level of most_frequent_element: input counter, cell chain, result register.
// Depends on mfe_pkg and mfe_cell.
//
// Usage: send the values of a set on req_item, one item per accepted
// req_valid/req_ready handshake, with req_item.last set on the final one.
// One result item per set comes out on rsp_item: the most frequent value
// (smallest signed value among ties), its count (saturated at 511) and a
// flag telling whether items beyond MAX_ITEMS were dropped.
// Throughput: one item per cycle while no result stalls the chain, sets back
// to back with no gap; each item travels down a chain of MAX_ITEMS cells, one
// cell per cycle, and merges into the cell holding its value or claims the
// first free one. Result: the closing item sweeps the chain, collecting the
// mode and emptying each cell for the next set; the result is registered
// from the end of the chain.
// Stall: while a result sits unaccepted on rsp_item the whole chain holds
// and req_ready is low; nothing is lost.
// Reset: synchronous, active high; empties every cell and the result slot.
`timescale 1ns / 1ps
`default_nettype none

module most_frequent_element #(
   parameter int MAX_ITEMS = mfe_pkg::DEFAULT_MAX_ITEMS
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire mfe_pkg::req_item_type  req_item,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output mfe_pkg::rsp_item_type       rsp_item
);
   import mfe_pkg::*;

   localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
   localparam int WIDE_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

   logic                advance;
   logic                req_fire;
   logic                full;
   logic [CNT_W-1:0]    fill_ff, fill_in;
   logic                ovf_ff, ovf_in;

   token_ctrl_type      entry_ctrl;
   token_ctrl_type      link_ctrl     [0:MAX_ITEMS];
   logic signed [31:0]  link_value    [0:MAX_ITEMS];
   logic signed [31:0]  link_best_val [0:MAX_ITEMS];
   logic [CNT_W-1:0]    link_best_cnt [0:MAX_ITEMS];

   logic                rsp_valid_ff, rsp_valid_in;
   rsp_item_type        rsp_item_ff, rsp_item_in;
   logic [WIDE_W-1:0]   tail_cnt;

   // the chain moves whenever the result slot can take what leaves it
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign req_fire  = req_valid && advance;
   assign full      = (fill_ff == CNT_W'(MAX_ITEMS));

   // per-set fill count and drop flag
   always_comb begin
      fill_in = fill_ff;
      ovf_in  = ovf_ff;
      if (req_fire) begin
         if (req_item.last) begin
            fill_in = '0;
            ovf_in  = 1'b0;
         end else if (full) begin
            ovf_in = 1'b1;
         end else begin
            fill_in = fill_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         ovf_ff  <= 1'b0;
      end else begin
         fill_ff <= fill_in;
         ovf_ff  <= ovf_in;
      end
   end

   // token entering the chain
   always_comb begin
      entry_ctrl.valid     = req_fire;
      entry_ctrl.has_value = !full;
      entry_ctrl.last      = req_item.last;
      entry_ctrl.overflow  = ovf_ff || full;
   end

   assign link_ctrl[0]     = entry_ctrl;
   assign link_value[0]    = req_item.value;
   assign link_best_val[0] = '0;
   assign link_best_cnt[0] = '0;

   // cell chain
   for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
      mfe_cell #(
         .CNT_W (CNT_W)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .advance     (advance),
         .up_ctrl     (link_ctrl[i]),
         .up_value    (link_value[i]),
         .up_best_val (link_best_val[i]),
         .up_best_cnt (link_best_cnt[i]),
         .dn_ctrl     (link_ctrl[i+1]),
         .dn_value    (link_value[i+1]),
         .dn_best_val (link_best_val[i+1]),
         .dn_best_cnt (link_best_cnt[i+1])
      );
   end

   // result from the closing token at the end of the chain
   always_comb begin
      tail_cnt               = WIDE_W'(link_best_cnt[MAX_ITEMS]);
      rsp_item_in.mode_value = link_best_val[MAX_ITEMS];
      rsp_item_in.overflow   = link_ctrl[MAX_ITEMS].overflow;
      if (tail_cnt > WIDE_W'(COUNT_MAX)) begin
         rsp_item_in.mode_count = COUNT_MAX;
      end else begin
         rsp_item_in.mode_count = tail_cnt[COUNT_W-1:0];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = link_ctrl[MAX_ITEMS].valid && link_ctrl[MAX_ITEMS].last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // checks
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(MAX_ITEMS))
      else $error("fill count beyond capacity");

   a_fill_clear: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_item.last) |=> (fill_ff == '0) && !ovf_ff)
      else $error("set state not cleared after last item");

   a_value_placed: assert property (@(posedge clock) disable iff (reset)
      !(link_ctrl[MAX_ITEMS].valid && link_ctrl[MAX_ITEMS].has_value))
      else $error("item left the chain without a cell");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_item_ff.mode_count != '0))
      else $error("result with zero count");

endmodule : most_frequent_element

`default_nettype wire

// ===== bench/most_frequent_element_tb.sv =====
// Self-checking bench for most_frequent_element: random and directed sets of values,
// with the mode of each set predicted here and compared with each result item.
// Depends on mfe_pkg and the most_frequent_element RTL.
`timescale 1ns / 1ps
`default_nettype none

module most_frequent_element_tb;
   import mfe_pkg::*;

   localparam int CAPACITY = DEFAULT_MAX_ITEMS;
   localparam int ITEMS_TARGET = 1950;
   localparam int HOLD_OFF_CYCLES = 800;
   localparam logic signed [31:0] VALUE_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] VALUE_MAX = 32'sh7FFF_FFFF;

   // receiver stall styles
   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_COIN,
      READY_SPARSE
   } ready_style_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_item_type req_item = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_item_type rsp_item;
   logic         hold_off = 1'b0;

   // items waiting to be offered, and modes waiting to come out
   req_item_type      pending_items[$];
   rsp_item_type      expected_modes[$];

   // predictor state: the set being collected
   logic signed [31:0] set_values[$];
   logic               set_dropped = 1'b0;
   logic signed [31:0] set_pool[4];

   int unsigned failures = 0;
   int unsigned items_taken = 0;
   int unsigned results_seen = 0;
   int unsigned sets_closed = 0;
   int unsigned overflow_sets = 0;
   int unsigned top_count = 0;
   int unsigned burst_left = 1;
   int unsigned gap_left = 0;
   int unsigned cycle_no = 0;
   ready_style_type ready_style = READY_ALWAYS;

   most_frequent_element #(
      .MAX_ITEMS(CAPACITY)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_item (req_item),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_item (rsp_item)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // add one item to the current set; on the closing item work out its mode
   task automatic absorb_item(input req_item_type it);
      rsp_item_type outcome;
      int unsigned  hits;
      int unsigned  best_hits;
      if (set_values.size() < CAPACITY) begin
         set_values.push_back(it.value);
      end else begin
         set_dropped = 1'b1;
      end
      if (it.last) begin
         best_hits = 0;
         outcome = '0;
         foreach (set_values[k]) begin
            hits = 0;
            foreach (set_values[j]) begin
               if (set_values[j] == set_values[k]) hits++;
            end
            // higher count wins, smaller signed value breaks a tie
            if (hits > best_hits ||
                (hits == best_hits && $signed(set_values[k]) < $signed(outcome.mode_value))) begin
               best_hits = hits;
               outcome.mode_value = set_values[k];
            end
         end
         outcome.mode_count = (best_hits > COUNT_MAX) ? COUNT_MAX : best_hits[COUNT_W-1:0];
         outcome.overflow = set_dropped;
         expected_modes.push_back(outcome);
         sets_closed++;
         if (set_dropped) overflow_sets++;
         if (best_hits > top_count) top_count = best_hits;
         set_values.delete();
         set_dropped = 1'b0;
      end
   endtask

   task automatic queue_item(input logic signed [31:0] value, input logic last);
      req_item_type it;
      it.value = value;
      it.last = last;
      pending_items.push_back(it);
   endtask

   // draw a value: mostly from the set's pool so that repeats and ties are common
   function automatic logic signed [31:0] pick_value();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return set_pool[$urandom_range(0, 3)];
      if (roll < 85) return int'($urandom_range(0, 8)) - 4;
      return $urandom;
   endfunction

   // sender: bursts of random length separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            absorb_item(req_item);
            items_taken++;
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0 || pending_items.size() == 0) begin
               if (gap_left > 0) gap_left--;
               req_valid <= 1'b0;
            end else begin
               req_item <= pending_items.pop_front();
               req_valid <= 1'b1;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 40);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end
            end
         end
      end
   end

   // receiver: check each result item, then pick the next ready value
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (expected_modes.size() == 0) begin
               failures++;
               $display("%0t: result with none expected: value %0d count %0d overflow %0b",
                        $time, rsp_item.mode_value, rsp_item.mode_count, rsp_item.overflow);
            end else begin
               rsp_item_type want;
               want = expected_modes.pop_front();
               if (rsp_item.mode_value !== want.mode_value) begin
                  failures++;
                  $display("%0t: mode_value expected %0d, got %0d",
                           $time, want.mode_value, rsp_item.mode_value);
               end
               if (rsp_item.mode_count !== want.mode_count) begin
                  failures++;
                  $display("%0t: mode_count expected %0d, got %0d",
                           $time, want.mode_count, rsp_item.mode_count);
               end
               if (rsp_item.overflow !== want.overflow) begin
                  failures++;
                  $display("%0t: overflow expected %0b, got %0b",
                           $time, want.overflow, rsp_item.overflow);
               end
            end
         end
         cycle_no++;
         if (cycle_no % 97 == 0) ready_style = ready_style_type'($urandom_range(0, 2));
         case (ready_style)
            READY_ALWAYS: begin
               rsp_ready <= !hold_off;
            end
            READY_COIN: begin
               rsp_ready <= !hold_off && ($urandom_range(0, 1) == 1);
            end
            default: begin
               rsp_ready <= !hold_off && (cycle_no % 5 == 0);
            end
         endcase
      end
   end

   // long receiver hold-off while the sender keeps going, so the chain backs up
   initial begin
      wait (results_seen >= 14);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_OFF_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   initial begin : stimulus
      int unsigned total;
      int unsigned set_no;
      int unsigned size;

      // directed: lone extremes, ties, full-range ties, repeats
      queue_item(VALUE_MIN, 1'b1);
      queue_item(VALUE_MAX, 1'b1);
      queue_item(0, 1'b1);
      queue_item(-1, 1'b1);
      queue_item(7, 1'b0);  queue_item(-3, 1'b0);
      queue_item(7, 1'b0);  queue_item(-3, 1'b1);
      queue_item(VALUE_MAX, 1'b0);  queue_item(VALUE_MIN, 1'b1);
      queue_item(-1, 1'b0);  queue_item(0, 1'b0);  queue_item(-1, 1'b0);
      queue_item(0, 1'b0);  queue_item(0, 1'b1);
      queue_item(3, 1'b0);  queue_item(2, 1'b0);  queue_item(1, 1'b1);
      queue_item(VALUE_MAX, 1'b0);  queue_item(VALUE_MAX, 1'b0);
      queue_item(VALUE_MAX, 1'b1);
      queue_item(-1, 1'b0);  queue_item(1, 1'b0);  queue_item(-1, 1'b0);
      queue_item(1, 1'b1);

      // random sets: mostly short, a few that fill or overrun the store
      total = pending_items.size();
      set_no = 0;
      while (total < ITEMS_TARGET) begin
         foreach (set_pool[i]) begin
            case ($urandom_range(0, 5))
               0: set_pool[i] = VALUE_MIN;
               1: set_pool[i] = VALUE_MAX;
               2: set_pool[i] = 0;
               3: set_pool[i] = -1;
               default: set_pool[i] = $urandom;
            endcase
         end
         case (set_no)
            10: size = CAPACITY;
            30: size = CAPACITY + 1;
            50: size = CAPACITY + $urandom_range(2, 40);
            default: size = $urandom_range(1, 24);
         endcase
         for (int k = 0; k < size; k++) queue_item(pick_value(), k == size - 1);
         total += size;
         set_no++;
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (pending_items.size() != 0 || req_valid || expected_modes.size() != 0) begin
         @(posedge clock);
      end
      repeat (CAPACITY + 20) @(posedge clock);

      $display("covered %0d items in %0d sets, %0d results checked", items_taken, sets_closed,
               results_seen);
      $display("sets over capacity: %0d, largest mode count: %0d", overflow_sets, top_count);
      if (failures == 0) begin
         $display("most_frequent_element regression: pass");
      end else begin
         $display("most_frequent_element regression: fail");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("most_frequent_element regression: fail");
      $finish;
   end

endmodule : most_frequent_element_tb

`default_nettype wire

// ===== files.f =====
hdl/mfe_pkg.sv
hdl/mfe_cell.sv
hdl/most_frequent_element.sv
bench/most_frequent_element_tb.sv
